>>> design/cdb_pkg.sv
// shared types, constants and pointer helpers for the circular deque buffer
package cdb_pkg;

	localparam int DEPTH   = 1024;
	localparam int DATA_W  = 32;
	localparam int PTR_W   = $clog2(DEPTH);
	localparam int FILL_W  = PTR_W + 1;
	localparam int COUNT_W = 10;
	localparam int VALUE_W = 32;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [DATA_W-1:0] elem_t;
	typedef logic [FILL_W-1:0] fill_t;

	localparam fill_t FILL_DEPTH = FILL_W'(DEPTH);
	localparam fill_t FILL_MAX   = FILL_W'(DEPTH - 1);
	localparam ptr_t  PTR_LAST   = PTR_W'(DEPTH - 1);

	typedef enum logic [2:0] {
		KIND_PUSH_FRONT = 3'd0,
		KIND_PUSH_BACK  = 3'd1,
		KIND_POP_FRONT  = 3'd2,
		KIND_POP_BACK   = 3'd3,
		KIND_CLEAR      = 3'd4,
		KIND_PEEK       = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic rd;
	} cmd_t;

	function automatic ptr_t step_up(input ptr_t i);
		return (i == PTR_LAST) ? '0 : ptr_t'(i + 1'b1);
	endfunction

	function automatic ptr_t step_down(input ptr_t i);
		return (i == '0) ? PTR_LAST : ptr_t'(i - 1'b1);
	endfunction

endpackage

>>> design/circular_deque_buffer_core.sv
// top level of the circular deque buffer: controller plus datapath
//
// A double-ended queue in a ring of 1024 slots, one kept free, so at most
// 1023 elements are held.
// Command channel: kind and value are taken at a rising edge where start is
// high and busy is low. kind selects push front, push back, pop front,
// pop back, clear or peek; value is stored only by a push.
// Result channel: status, count, not_empty, front_value and back_value are
// valid for exactly one cycle while done is high. The receiver cannot stall.
// Sequence: after the accepting edge the pointers are updated and the ring
// written, then both ends of the ring are read through registers, then the
// result is shown with done high.
// A new command is not taken while one is in progress; the next may be
// accepted in the same cycle its predecessor's result is on done. The
// pace is set by the registered read of the ring memory that follows
// each pointer update.
// Reset (arst_n low) empties the deque and returns the controller to idle;
// ring contents are not cleared; unreachable entries never reach the outputs.
// A push into a full ring or a pop from an empty one reports an error
// status and changes nothing.
module circular_deque_buffer_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         kind,
	input  logic signed [31:0] value,
	output logic               done,
	output logic [1:0]         status,
	output logic [9:0]         count,
	output logic               not_empty,
	output logic signed [31:0] front_value,
	output logic signed [31:0] back_value
);
	import cdb_pkg::*;

	cmd_t cmd;

	cdb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	cdb_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.kind        (kind),
		.value       (value),
		.status      (status),
		.count       (count),
		.not_empty   (not_empty),
		.front_value (front_value),
		.back_value  (back_value)
	);

endmodule

>>> design/cdb_ctrl.sv
// controller state machine sequencing accept, update, read and result
module cdb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output cdb_pkg::cmd_t cmd
);
	import cdb_pkg::*;

	state_t state_q;
	state_t state_nx;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		busy     = 1'b0;
		done     = 1'b0;
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
				state_nx = ST_READ;
			end
			ST_READ: begin
				busy     = 1'b1;
				cmd.rd   = 1'b1;
				state_nx = ST_DONE;
			end
			ST_DONE: begin
				done     = 1'b1;
				state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
		// a new beat may enter while the result is out
		accept   = start && !busy;
		cmd.load = accept;
		if (accept) begin
			state_nx = ST_EXEC;
		end
	end

endmodule

>>> design/cdb_datapath.sv
// datapath: pointers, ring memory, status and result formatting
module cdb_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cdb_pkg::cmd_t                cmd,
	input  logic [2:0]                   kind,
	input  logic signed [31:0]           value,
	output logic [1:0]                   status,
	output logic [9:0]                   count,
	output logic                         not_empty,
	output logic signed [31:0]           front_value,
	output logic signed [31:0]           back_value
);
	import cdb_pkg::*;

	elem_t   ring_mem [DEPTH];
	kind_t   kind_q;
	elem_t   value_q;
	ptr_t    head_q;
	ptr_t    tail_q;
	status_t status_q;
	elem_t   front_q;
	elem_t   back_q;

	fill_t   fill;
	logic    full;
	logic    empty;
	ptr_t    head_nx;
	ptr_t    tail_nx;
	status_t status_nx;
	logic    wr_en;
	ptr_t    wr_addr;

	always_comb begin
		if (tail_q >= head_q) begin
			fill = {1'b0, ptr_t'(tail_q - head_q)};
		end else begin
			fill = fill_t'(FILL_DEPTH - {1'b0, ptr_t'(head_q - tail_q)});
		end
		full  = (fill >= FILL_MAX);
		empty = (fill == '0);
	end

	always_comb begin
		head_nx   = head_q;
		tail_nx   = tail_q;
		status_nx = STATUS_OK;
		wr_en     = 1'b0;
		wr_addr   = tail_q;
		case (kind_q)
			KIND_PUSH_FRONT: begin
				if (full) begin
					status_nx = STATUS_FULL;
				end else begin
					head_nx = step_down(head_q);
					wr_en   = 1'b1;
					wr_addr = step_down(head_q);
				end
			end
			KIND_PUSH_BACK: begin
				if (full) begin
					status_nx = STATUS_FULL;
				end else begin
					tail_nx = step_up(tail_q);
					wr_en   = 1'b1;
					wr_addr = tail_q;
				end
			end
			KIND_POP_FRONT: begin
				if (empty) begin
					status_nx = STATUS_EMPTY;
				end else begin
					head_nx = step_up(head_q);
				end
			end
			KIND_POP_BACK: begin
				if (empty) begin
					status_nx = STATUS_EMPTY;
				end else begin
					tail_nx = step_down(tail_q);
				end
			end
			KIND_CLEAR: begin
				head_nx = '0;
				tail_nx = '0;
			end
			default: begin
				// peek and unused codes leave everything as is
				status_nx = STATUS_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (cmd.exec) begin
			head_q <= head_nx;
			tail_q <= tail_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind_t'(kind);
			value_q <= elem_t'(value);
		end
		if (cmd.exec) begin
			status_q <= status_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			ring_mem[wr_addr] <= value_q;
		end
	end

	// both ends read in the cycle after the pointer update
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			front_q <= ring_mem[head_q];
			back_q  <= ring_mem[step_down(tail_q)];
		end
	end

	assign status      = status_q;
	assign count       = COUNT_W'(fill);
	assign not_empty   = !empty;
	assign front_value = empty ? '0 : signed'(VALUE_W'(front_q));
	assign back_value  = empty ? '0 : signed'(VALUE_W'(back_q));

endmodule
